// File: rtl/modular_exponentiation_macros.svh
// assertion macros shared by the modular exponentiation rtl
// no dependencies; included by the files that carry assertions
`ifndef MODULAR_EXPONENTIATION_MACROS_SVH
`define MODULAR_EXPONENTIATION_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)

`endif

`endif

// File: rtl/modexp_pkg.sv
// shared types and constants of the modular exponentiation block
// no dependencies
`default_nettype none

package modexp_pkg;

   // fixed field widths
   localparam int REG_W     = 32;
   localparam int VALUE_W   = 32;
   localparam int CSR_IDX_W = 1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODULUS  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 1'b1;

   // register reset values, cut down to the datapath width where used
   localparam logic [63:0] MODULUS_RST  = 64'd64507;
   localparam logic [63:0] EXPONENT_RST = 64'd65537;

   // largest valid decrypted byte
   localparam logic [63:0] BYTE_MAX = 64'd255;

   // sequencer states
   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_REDUCE = 6'b000010,
      S_EVAL   = 6'b000100,
      S_MULT   = 6'b001000,
      S_SQUARE = 6'b010000,
      S_FINISH = 6'b100000
   } state_type;

   // status of the modular multiplier
   typedef struct packed {
      logic busy;
      logic done;
   } mm_status_type;

endpackage

`default_nettype wire

// File: rtl/modular_exponentiation.sv
// modular exponentiation top level: csr registers, square-and-multiply sequencer,
// result register; depends on modexp_pkg, modexp_mulmod, macros header
//
//   channel  ports                                  direction  beat
//   req      req_valid req_stall req_value            in       one base value
//   rsp      rsp_valid rsp_stall rsp_result, flags    out      one result per req
//   csr      csr_write csr_index csr_wdata            in       one register write
//
// an accepted item first reduces its base with one modular multiply, then walks the
// exponent from its lowest bit, multiplying for each set bit and squaring while higher
// bits remain; each modular multiply runs one bit per cycle in modexp_mulmod. a zero
// exponent goes straight to the response after the reduction, and a zero modulus
// skips the multiplier altogether.
// reset is synchronous and active high; registers return to modulus 64507 and
// exponent 65537. req is stalled while an item is at work; a finished result
// waits in the output register while rsp is stalled and a new req is accepted.
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modular_exponentiation #(
   parameter int WIDTH = 32
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request channel
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [modexp_pkg::VALUE_W-1:0]      req_value,
   // response channel
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [modexp_pkg::VALUE_W-1:0]      rsp_result,
   output logic                                     rsp_input_too_large,
   output logic                                     rsp_result_exceeds_byte,
   // configuration port
   input  wire logic                                csr_write,
   input  wire logic [modexp_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [modexp_pkg::REG_W-1:0]        csr_wdata
);
   import modexp_pkg::*;

   localparam logic [WIDTH-1:0] BYTE_LIMIT = BYTE_MAX[WIDTH-1:0];

   state_type        state_ff, state_in;
   logic [WIDTH-1:0] modulus_ff, modulus_in;
   logic [WIDTH-1:0] exponent_ff, exponent_in;
   logic [WIDTH-1:0] exp_ff, exp_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] base_ff, base_in;
   logic             too_large_ff, too_large_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0] rsp_result_ff, rsp_result_in;
   logic             rsp_too_large_ff, rsp_too_large_in;
   logic             rsp_exceeds_ff, rsp_exceeds_in;

   logic             req_beat;
   logic             rsp_beat;
   logic [63:0]      wdata_ext;
   logic [63:0]      value_ext;
   logic [63:0]      modulus_ext;
   logic [63:0]      res_ext;
   logic [WIDTH-1:0] value_w;
   logic [WIDTH-1:0] exp_shift;
   logic             mm_start;
   logic [WIDTH-1:0] mm_a;
   logic [WIDTH-1:0] mm_b;
   logic [WIDTH-1:0] mm_product;
   mm_status_type    mm_status;

   assign req_beat    = req_valid && !req_stall;
   assign rsp_beat    = rsp_valid_ff && !rsp_stall;
   assign wdata_ext   = {32'b0, csr_wdata};
   assign value_ext   = {32'b0, req_value};
   assign modulus_ext = {{(64 - WIDTH){1'b0}}, modulus_ff};
   assign res_ext     = {{(64 - WIDTH){1'b0}}, res_ff};
   assign value_w     = value_ext[WIDTH-1:0];
   assign exp_shift   = {1'b0, exp_ff[WIDTH-1:1]};

   // configuration writes
   always_comb begin
      modulus_in  = modulus_ff;
      exponent_in = exponent_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_MODULUS: begin
               modulus_in = wdata_ext[WIDTH-1:0];
            end
            CSR_EXPONENT: begin
               exponent_in = wdata_ext[WIDTH-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // square-and-multiply sequencer
   always_comb begin
      state_in         = state_ff;
      exp_in           = exp_ff;
      res_in           = res_ff;
      base_in          = base_ff;
      too_large_in     = too_large_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_beat;
      rsp_result_in    = rsp_result_ff;
      rsp_too_large_in = rsp_too_large_ff;
      rsp_exceeds_in   = rsp_exceeds_ff;
      mm_start         = 1'b0;
      mm_a             = res_ff;
      mm_b             = base_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               too_large_in = value_ext >= modulus_ext;
               exp_in       = exponent_ff;
               if (modulus_ff == '0) begin
                  res_in   = '0;
                  state_in = S_FINISH;
               end else begin
                  // reduce the base as 1 * value mod m
                  res_in   = WIDTH'(1);
                  mm_start = 1'b1;
                  mm_a     = WIDTH'(1);
                  mm_b     = value_w;
                  state_in = S_REDUCE;
               end
            end
         end
         S_REDUCE: begin
            if (mm_status.done) begin
               base_in  = mm_product;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (exp_ff == '0) begin
               state_in = S_FINISH;
            end else if (exp_ff[0]) begin
               mm_start = 1'b1;
               state_in = S_MULT;
            end else begin
               exp_in   = exp_shift;
               mm_start = 1'b1;
               mm_a     = base_ff;
               state_in = S_SQUARE;
            end
         end
         S_MULT: begin
            if (mm_status.done) begin
               res_in = mm_product;
               exp_in = exp_shift;
               // skip the final squaring, it no longer reaches the result
               if (exp_shift != '0) begin
                  mm_start = 1'b1;
                  mm_a     = base_ff;
                  state_in = S_SQUARE;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SQUARE: begin
            if (mm_status.done) begin
               base_in  = mm_product;
               state_in = S_EVAL;
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_beat) begin
               rsp_valid_in     = 1'b1;
               rsp_result_in    = res_ext[VALUE_W-1:0];
               rsp_too_large_in = too_large_ff;
               rsp_exceeds_in   = res_ff > BYTE_LIMIT;
               state_in         = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         modulus_ff   <= MODULUS_RST[WIDTH-1:0];
         exponent_ff  <= EXPONENT_RST[WIDTH-1:0];
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         modulus_ff   <= modulus_in;
         exponent_ff  <= exponent_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      exp_ff           <= exp_in;
      res_ff           <= res_in;
      base_ff          <= base_in;
      too_large_ff     <= too_large_in;
      rsp_result_ff    <= rsp_result_in;
      rsp_too_large_ff <= rsp_too_large_in;
      rsp_exceeds_ff   <= rsp_exceeds_in;
   end

   // shared bit-serial modular multiplier
   modexp_mulmod #(
      .WIDTH(WIDTH)
   ) u_mulmod (
      .clock      (clock),
      .reset      (reset),
      .start      (mm_start),
      .a          (mm_a),
      .b          (mm_b),
      .m          (modulus_ff),
      .status_out (mm_status),
      .product    (mm_product)
   );

   assign req_stall               = state_ff != S_IDLE;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_result              = rsp_result_ff;
   assign rsp_input_too_large     = rsp_too_large_ff;
   assign rsp_result_exceeds_byte = rsp_exceeds_ff;

   `ASSERT_CLK(a_accept_busy, clock, reset,
      req_beat |=> (state_ff == S_REDUCE || state_ff == S_FINISH),
      "accepted beat did not start work")
   `ASSERT_NEVER(a_start_free, clock, reset, mm_start && mm_status.busy,
      "multiplier started while busy")
   `ASSERT_CLK(a_rsp_from_finish, clock, reset,
      $rose(rsp_valid_ff) |-> $past(state_ff == S_FINISH),
      "response beat without finished item")
   `ASSERT_NEVER(a_done_idle, clock, reset,
      mm_status.done && (state_ff == S_IDLE || state_ff == S_EVAL || state_ff == S_FINISH),
      "multiplier done while sequencer not waiting")

endmodule

`default_nettype wire

// File: rtl/modexp_mulmod.sv
// bit-serial modular multiplier: product = a * b mod m, one bit of b per cycle
// depends on modexp_pkg and modular_exponentiation_macros.svh
`default_nettype none
`include "modular_exponentiation_macros.svh"

module modexp_mulmod #(
   parameter int WIDTH = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     a,
   input  wire logic [WIDTH-1:0]     b,
   input  wire logic [WIDTH-1:0]     m,
   output modexp_pkg::mm_status_type status_out,
   output logic      [WIDTH-1:0]     product
);
   import modexp_pkg::*;

   localparam int CNT_W = $clog2(WIDTH);

   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] m_ff, m_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   // (x + y) mod mod_v for x < mod_v and y <= mod_v
   function automatic logic [WIDTH-1:0] add_mod(input logic [WIDTH-1:0] x,
                                                input logic [WIDTH-1:0] y,
                                                input logic [WIDTH-1:0] mod_v);
      logic [WIDTH:0] sum;
      logic [WIDTH:0] diff;
      sum  = {1'b0, x} + {1'b0, y};
      diff = sum - {1'b0, mod_v};
      if (sum >= {1'b0, mod_v}) begin
         return diff[WIDTH-1:0];
      end
      return sum[WIDTH-1:0];
   endfunction

   // one step: double the accumulator, add a when the next bit of b is set
   always_comb begin
      logic [WIDTH-1:0] dbl;
      a_in    = a_ff;
      b_in    = b_ff;
      m_in    = m_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      dbl     = add_mod(acc_ff, acc_ff, m_ff);
      if (start) begin
         a_in    = a;
         b_in    = b;
         m_in    = m;
         acc_in  = '0;
         cnt_in  = CNT_W'(WIDTH - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         acc_in = b_ff[WIDTH-1] ? add_mod(dbl, a_ff, m_ff) : dbl;
         b_in   = {b_ff[WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      m_ff   <= m_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
   end

   assign status_out.busy = busy_ff;
   assign status_out.done = done_ff;
   assign product         = acc_ff;

   `ASSERT_CLK(a_start_busy, clock, reset, start |=> busy_ff, "multiplier not busy after start")
   `ASSERT_CLK(a_last_done, clock, reset, (busy_ff && !start && cnt_ff == '0) |=> done_ff, "missing done after last step")
   `ASSERT_NEVER(a_done_busy, clock, reset, done_ff && busy_ff, "done while still busy")
   `ASSERT_CLK(a_acc_range, clock, reset, busy_ff |-> acc_ff < m_ff, "accumulator not reduced")

endmodule

`default_nettype wire

// File: verif/tb_modular_exponentiation.sv
// testbench for modular_exponentiation: directed corner values, then random beats under
// several modulus and exponent settings; results checked against an in-bench predictor
// depends on modexp_pkg and the modular_exponentiation rtl
`default_nettype none

module tb_modular_exponentiation;
   import modexp_pkg::*;

   localparam int HOLD_CYCLES  = 1500;
   localparam int DRAIN_CYCLES = 2300;

   // one expected response beat
   typedef struct {
      logic [VALUE_W-1:0] result;
      logic               too_large;
      logic               exceeds_byte;
   } power_result_type;

   logic clock;
   logic reset = 1'b1;

   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [VALUE_W-1:0]   req_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [VALUE_W-1:0]   rsp_result;
   logic                 rsp_input_too_large;
   logic                 rsp_result_exceeds_byte;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_MODULUS;
   logic [REG_W-1:0]     csr_wdata = '0;

   // register copies as the block should hold them
   logic [REG_W-1:0] cfg_modulus  = MODULUS_RST[REG_W-1:0];
   logic [REG_W-1:0] cfg_exponent = EXPONENT_RST[REG_W-1:0];

   logic [VALUE_W-1:0] pending_values[$];
   power_result_type   expected_powers[$];
   int unsigned        mismatch_count = 0;
   bit                 idling_on = 1'b1;
   logic               hold_trigger = 1'b0;
   int unsigned        hold_left = 0;
   int unsigned        req_gap_left = 0;

   modular_exponentiation DUT (
      .clock                   (clock),
      .reset                   (reset),
      .req_valid               (req_valid),
      .req_stall               (req_stall),
      .req_value               (req_value),
      .rsp_valid               (rsp_valid),
      .rsp_stall               (rsp_stall),
      .rsp_result              (rsp_result),
      .rsp_input_too_large     (rsp_input_too_large),
      .rsp_result_exceeds_byte (rsp_result_exceeds_byte),
      .csr_write               (csr_write),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // value^exponent mod modulus with full 64-bit products
   function automatic power_result_type predict_power(input logic [VALUE_W-1:0] base_value);
      power_result_type r;
      logic [63:0]      acc;
      logic [63:0]      sq;
      logic [63:0]      n;
      logic [63:0]      e;
      n = cfg_modulus;
      e = cfg_exponent;
      // zero modulus: nothing to reduce by, flagged as too large
      if (n == 0) begin
         r.result       = '0;
         r.too_large    = 1'b1;
         r.exceeds_byte = 1'b0;
         return r;
      end
      // the start value 1 stays unreduced when the exponent is zero
      acc = 64'd1;
      sq  = base_value % n;
      while (e != 0) begin
         if (e[0]) begin
            acc = (acc * sq) % n;
         end
         sq = (sq * sq) % n;
         e  = e >> 1;
      end
      r.result       = acc[VALUE_W-1:0];
      r.too_large    = (base_value >= n);
      r.exceeds_byte = (acc > BYTE_MAX);
      return r;
   endfunction

   // mostly values below the modulus, the rest anywhere in the field
   function automatic logic [VALUE_W-1:0] pick_value();
      if (cfg_modulus != 0 && $urandom_range(0, 9) < 6) begin
         return $urandom % cfg_modulus;
      end
      return $urandom;
   endfunction

   // request driver: offers pending values, random gaps, holds a stalled beat
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_powers = {expected_powers, predict_power(req_value)};
         end
         if (req_valid && req_stall) begin
            // beat stays as it is until taken
         end else if (req_gap_left != 0) begin
            req_gap_left--;
            req_valid <= 1'b0;
         end else if (pending_values.size() != 0) begin
            if (idling_on && $urandom_range(0, 7) == 0) begin
               req_gap_left = $urandom_range(1, 18) - 1;
               req_valid <= 1'b0;
            end else begin
               req_valid <= 1'b1;
               req_value <= pending_values.pop_front();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // long receiver hold-off, counted here
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_trigger) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor: checks each taken beat, random stall bursts
   int unsigned rsp_gap_left = 0;
   always @(posedge clock) begin
      power_result_type want;
      logic             burst;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_gap_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_powers.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual result %h",
                        $time, rsp_result);
               mismatch_count++;
            end else begin
               want = expected_powers.pop_front();
               if (rsp_result !== want.result) begin
                  $display("%0t: result mismatch, expected %h, actual %h",
                           $time, want.result, rsp_result);
                  mismatch_count++;
               end
               if (rsp_input_too_large !== want.too_large) begin
                  $display("%0t: input_too_large mismatch, expected %b, actual %b",
                           $time, want.too_large, rsp_input_too_large);
                  mismatch_count++;
               end
               if (rsp_result_exceeds_byte !== want.exceeds_byte) begin
                  $display("%0t: result_exceeds_byte mismatch, expected %b, actual %b",
                           $time, want.exceeds_byte, rsp_result_exceeds_byte);
                  mismatch_count++;
               end
            end
         end
         burst = 1'b0;
         if (rsp_gap_left != 0) begin
            rsp_gap_left--;
            burst = 1'b1;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_gap_left = $urandom_range(1, 18) - 1;
            burst = 1'b1;
         end
         rsp_stall <= burst || (hold_left != 0);
      end
   end

   // block is idle once nothing is queued, offered or outstanding
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_values.size() != 0 || req_valid || expected_powers.size() != 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [REG_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_MODULUS:  cfg_modulus = data;
         CSR_EXPONENT: cfg_exponent = data;
         default: ;
      endcase
   endtask

   task automatic configure(input logic [REG_W-1:0] n, input logic [REG_W-1:0] e);
      wait_idle();
      write_csr(CSR_MODULUS, n);
      write_csr(CSR_EXPONENT, e);
      @(negedge clock);
   endtask

   // append one value to the driver queue
   task automatic queue_value(input logic [VALUE_W-1:0] v);
      pending_values = {pending_values, v};
   endtask

   task automatic queue_random(input int count);
      repeat (count) queue_value(pick_value());
   endtask

   // stimulus sequence
   initial begin
      logic [VALUE_W-1:0] corner_values[11];
      logic [REG_W-1:0]   n;
      logic [REG_W-1:0]   e;
      corner_values = '{32'd0, 32'd1, 32'd2, 32'd255, 32'd256, 32'd64506, 32'd64507,
                        32'd64508, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, values around the default modulus and field extremes
      foreach (corner_values[i]) queue_value(corner_values[i]);

      // largest modulus and exponent
      configure(32'hffff_ffff, 32'hffff_ffff);
      queue_value(32'hffff_fffe);
      queue_value(32'hffff_ffff);
      queue_value(32'h1234_5678);

      // exponent zero with modulus one gives an unreduced one
      configure(32'd1, 32'd0);
      queue_value(32'd0);
      queue_value(32'hffff_ffff);

      // modulus one with a nonzero exponent
      configure(32'd1, 32'd5);
      queue_value(32'd7);
      queue_value(32'd0);

      // zero modulus
      configure(32'd0, 32'd65537);
      queue_value(32'd0);
      queue_value(32'd5);
      queue_value(32'hffff_ffff);

      // exponent zero with a large modulus
      configure($urandom | 32'h8000_0000, 32'd0);
      queue_value(32'd123);
      queue_value(32'hffff_ffff);

      // random settings, one family per phase
      for (int p = 0; p < 12; p++) begin
         case (p % 6)
            0: begin
               n = $urandom_range(2, 300);
               e = $urandom;
            end
            1: begin
               n = $urandom;
               e = $urandom;
            end
            2: begin
               n = $urandom_range(256, 65535);
               e = $urandom_range(1, 20);
            end
            3: begin
               n = $urandom | 32'h8000_0000;
               e = 32'd65537;
            end
            4: begin
               n = (p < 6) ? 32'd0 : $urandom_range(1, 4);
               e = $urandom;
            end
            default: begin
               n = $urandom;
               e = $urandom_range(0, 3);
            end
         endcase
         configure(n, e);
         queue_random(20);
      end

      // receiver holds off while the sender keeps offering
      configure($urandom, 32'd3);
      @(posedge clock);
      hold_trigger <= 1'b1;
      @(posedge clock);
      hold_trigger <= 1'b0;
      @(negedge clock);
      queue_random(15);

      // last stretch runs without idling
      wait_idle();
      idling_on = 1'b0;
      configure($urandom, $urandom_range(0, 65535));
      queue_random(12);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // run limit, several times the slowest correct run
   initial begin
      #40_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/modexp_pkg.sv
rtl/modexp_mulmod.sv
rtl/modular_exponentiation.sv
verif/tb_modular_exponentiation.sv
